@@ rtl/ilid_pkg.sv @@
// Package for the indexed list insert/delete unit.
// Holds field widths, request and status codes and the result record.
// No dependencies.
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int TYPE_W   = 3;
    localparam int POS_W    = 9;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_WRITE  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/ilid_ram.sv @@
// Element store of the indexed list unit: one write port and one read
// port, read data registered. No package dependencies.
`default_nettype none

module ilid_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ilid_seq.sv @@
// Request sequencer of the indexed list unit: checks each request, keeps the
// length and drives the element store, moving one element per cycle.
// Depends on ilid_pkg.
`default_nettype none

module ilid_seq #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [ilid_pkg::TYPE_W-1:0]       req_type,
    input  wire logic [ilid_pkg::POS_W-1:0]        position,
    input  wire logic [ilid_pkg::WORD_W-1:0]       word_in,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output ilid_pkg::res_t                         res,
    output logic                                   wr_en,
    output logic [$clog2(CAPACITY)-1:0]            wr_addr,
    output logic [ilid_pkg::WORD_W-1:0]            wr_data,
    output logic                                   rd_en,
    output logic [$clog2(CAPACITY)-1:0]            rd_addr,
    input  wire logic [ilid_pkg::WORD_W-1:0]       rd_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > ilid_pkg::POS_W) ? LEN_W : ilid_pkg::POS_W;
    localparam logic [ADDR_W-1:0] ONE_A = 1;
    localparam logic [LEN_W-1:0]  ONE_L = 1;
    localparam logic [LEN_W-1:0]  CAP_L = LEN_W'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_RDWAIT = 6'b000010,
        S_SHDN   = 6'b000100,
        S_SHUP   = 6'b001000,
        S_PUT    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                               state_reg, state_next;
    logic [LEN_W-1:0]                     len_reg, len_next;
    logic [ADDR_W-1:0]                    ptr_reg, ptr_next;
    logic [ADDR_W-1:0]                    pos_reg, pos_next;
    logic [ilid_pkg::WORD_W-1:0]          win_reg, win_next;
    logic [ilid_pkg::WORD_W-1:0]          rword_reg, rword_next;
    logic [ilid_pkg::STATUS_W-1:0]        status_reg, status_next;

    logic                                 acc;
    logic [CMP_W-1:0]                     pos_ext, len_ext, len_m1_ext;
    logic [LEN_W-1:0]                     len_m1;
    logic [ADDR_W-1:0]                    pos_a, len_a, len_m1_a;
    logic                                 in_range, ins_range, full;

    assign req_ready = (state_reg == S_IDLE);
    assign acc       = req_valid && req_ready;
    assign res_valid = (state_reg == S_DONE);

    assign len_m1     = len_reg - ONE_L;
    assign pos_ext    = CMP_W'(position);
    assign len_ext    = CMP_W'(len_reg);
    assign len_m1_ext = CMP_W'(len_m1);
    assign pos_a      = pos_ext[ADDR_W-1:0];
    assign len_a      = len_ext[ADDR_W-1:0];
    assign len_m1_a   = len_m1_ext[ADDR_W-1:0];
    assign in_range   = pos_ext < len_ext;
    assign ins_range  = pos_ext <= len_ext;
    assign full       = (len_reg == CAP_L);

    assign res.word_out = rword_reg;
    assign res.count    = len_ext[ilid_pkg::COUNT_W-1:0];
    assign res.status   = status_reg;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        win_next    = win_reg;
        rword_next  = rword_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    state_next  = S_DONE;
                    rword_next  = '0;
                    status_next = ilid_pkg::ST_OK;
                    pos_next    = pos_a;
                    win_next    = word_in;
                    case (req_type)
                        ilid_pkg::REQ_APPEND: begin
                            if (full) begin
                                status_next = ilid_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = len_a;
                                wr_data  = word_in;
                                len_next = len_reg + ONE_L;
                            end
                        end
                        ilid_pkg::REQ_READ: begin
                            if (!in_range) begin
                                status_next = ilid_pkg::ST_RANGE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_a;
                                state_next = S_RDWAIT;
                            end
                        end
                        ilid_pkg::REQ_WRITE: begin
                            if (!in_range) begin
                                status_next = ilid_pkg::ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_a;
                                wr_data = word_in;
                            end
                        end
                        ilid_pkg::REQ_DELETE: begin
                            if (!in_range) begin
                                status_next = ilid_pkg::ST_RANGE;
                            end else if (pos_ext == len_m1_ext) begin
                                len_next = len_m1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_a + ONE_A;
                                ptr_next   = pos_a + ONE_A;
                                state_next = S_SHDN;
                            end
                        end
                        ilid_pkg::REQ_INSERT: begin
                            if (!ins_range) begin
                                status_next = ilid_pkg::ST_RANGE;
                            end else if (full) begin
                                status_next = ilid_pkg::ST_FULL;
                            end else if (pos_ext == len_ext) begin
                                wr_en    = 1'b1;
                                wr_addr  = pos_a;
                                wr_data  = word_in;
                                len_next = len_reg + ONE_L;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = len_m1_a;
                                ptr_next   = len_m1_a;
                                state_next = S_SHUP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                rword_next = rd_data;
                state_next = S_DONE;
            end
            S_SHDN: begin
                // The word read last cycle moves down one place.
                wr_en   = 1'b1;
                wr_addr = ptr_reg - ONE_A;
                if ((LEN_W'(ptr_reg) + ONE_L) < len_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + ONE_A;
                    ptr_next = ptr_reg + ONE_A;
                end else begin
                    len_next   = len_m1;
                    state_next = S_DONE;
                end
            end
            S_SHUP: begin
                // The word read last cycle moves up one place.
                wr_en   = 1'b1;
                wr_addr = ptr_reg + ONE_A;
                if (ptr_reg > pos_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - ONE_A;
                    ptr_next = ptr_reg - ONE_A;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = win_reg;
                len_next   = len_reg + ONE_L;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        win_reg    <= win_next;
        rword_reg  <= rword_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

@@ rtl/indexed_list_insert_delete_unit.sv @@
// Indexed list unit: an ordered list of signed 32-bit words in one memory.
// Depends on ilid_pkg, ilid_seq and ilid_ram.
//
// Requests arrive on the s_ channel: s_tuser carries the request type and
// s_tdata the position and the word. Each request yields exactly one result
// word on the m_ channel: the read word and the length in m_tdata, the
// status in m_tuser. A bad index or a full list is rejected with a status
// and leaves the list unchanged.
// One request is worked at a time. A read waits for the registered memory
// data. Delete short of the last element and insert below the end shift the
// elements behind the position, as the single memory moves one element per
// cycle. The next request is accepted once the result has left the sequencer
// for the output register.
// The result sits in an output register, so a stalled receiver does not
// block the next request; only a second finished result waits for it.
// Synchronous reset empties the list; the memory itself is not cleared.
`default_nettype none

module indexed_list_insert_delete_unit #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // position [8:0], word_in [40:9], zero fill above
    input  wire logic [ilid_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type [2:0]
    input  wire logic [ilid_pkg::TYPE_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // word_out [31:0], count [40:32], zero fill above
    output logic [ilid_pkg::M_TDATA_W-1:0]          m_tdata,
    // status [1:0]
    output logic [ilid_pkg::STATUS_W-1:0]           m_tuser
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int RES_W  = ilid_pkg::WORD_W + ilid_pkg::COUNT_W;

    ilid_pkg::res_t              res;
    logic                        res_valid, res_ready;
    logic                        wr_en, rd_en;
    logic [ADDR_W-1:0]           wr_addr, rd_addr;
    logic [ilid_pkg::WORD_W-1:0] wr_data, rd_data;

    logic                          m_tvalid_reg;
    logic [RES_W-1:0]              m_data_reg;
    logic [ilid_pkg::STATUS_W-1:0] m_tuser_reg;

    ilid_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser),
        .position  (s_tdata[ilid_pkg::POS_W-1:0]),
        .word_in   (s_tdata[ilid_pkg::POS_W +: ilid_pkg::WORD_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ilid_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (ilid_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg  <= {res.count, res.word_out};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ilid_pkg::M_TDATA_W'(m_data_reg);
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ rtl/ilid_chk.sv @@
// Port checker for the indexed list unit, bound to the top level.
// Depends on ilid_pkg.
`default_nettype none

module ilid_chk #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ilid_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [ilid_pkg::STATUS_W-1:0]  m_tuser
);

    localparam logic [ilid_pkg::COUNT_W-1:0] CAP_CNT = ilid_pkg::COUNT_W'(CAPACITY);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result word changed while stalled.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word shown right after reset.");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ilid_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("Rejected request returned a nonzero word.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ilid_pkg::ST_FULL) |-> (m_tdata[40:32] == CAP_CNT))
        else $error("Full status reported with a length below capacity.");

endmodule

bind indexed_list_insert_delete_unit ilid_chk #(
    .CAPACITY (CAPACITY)
) u_ilid_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for indexed_list_insert_delete_unit: a table of directed
// requests, then random request streams checked word by word against a list predictor.
// Depends on ilid_pkg and the indexed_list_insert_delete_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = ilid_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [ilid_pkg::TYPE_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [ilid_pkg::TYPE_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [ilid_pkg::TYPE_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int TREND_GROW   = 0;
    localparam int TREND_CHURN  = 1;
    localparam int TREND_SHRINK = 2;

    typedef struct packed {
        logic [ilid_pkg::TYPE_W-1:0]        kind;
        logic [ilid_pkg::POS_W-1:0]         pos;
        logic signed [ilid_pkg::WORD_W-1:0] word;
    } list_req_t;

    typedef struct {
        list_req_t      req;
        bit             typed;
        ilid_pkg::res_t want;
    } table_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ilid_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [ilid_pkg::TYPE_W-1:0]    s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ilid_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ilid_pkg::STATUS_W-1:0]  m_tuser;

    logic signed [ilid_pkg::WORD_W-1:0] list_words [CAP];
    int             list_len     = 0;
    ilid_pkg::res_t pending_results [$];
    table_row_t     directed_rows [$];
    int             err_count    = 0;
    int             results_seen = 0;
    int             tx_idle_pct  = 11;
    int             rx_idle_pct  = 74;
    int             hold_left    = 0;
    bit             hold_done    = 1'b0;
    int             cycle_count  = 0;

    indexed_list_insert_delete_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    task automatic log_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic ilid_pkg::res_t apply_request(input list_req_t r);
        ilid_pkg::res_t o;
        int             p;
        p = int'(r.pos);
        o.word_out = '0;
        o.status   = ilid_pkg::ST_OK;
        case (r.kind)
            ilid_pkg::REQ_APPEND: begin
                if (list_len >= CAP) begin
                    o.status = ilid_pkg::ST_FULL;
                end else begin
                    list_words[list_len] = r.word;
                    list_len++;
                end
            end
            ilid_pkg::REQ_READ: begin
                if (p >= list_len) o.status = ilid_pkg::ST_RANGE;
                else o.word_out = list_words[p];
            end
            ilid_pkg::REQ_WRITE: begin
                if (p >= list_len) o.status = ilid_pkg::ST_RANGE;
                else list_words[p] = r.word;
            end
            ilid_pkg::REQ_DELETE: begin
                if (p >= list_len) begin
                    o.status = ilid_pkg::ST_RANGE;
                end else begin
                    for (int k = p; k < list_len - 1; k++) list_words[k] = list_words[k + 1];
                    list_len--;
                end
            end
            ilid_pkg::REQ_INSERT: begin
                if (p > list_len) begin
                    o.status = ilid_pkg::ST_RANGE;
                end else if (list_len >= CAP) begin
                    o.status = ilid_pkg::ST_FULL;
                end else begin
                    for (int k = list_len; k > p; k--) list_words[k] = list_words[k - 1];
                    list_words[p] = r.word;
                    list_len++;
                end
            end
            default: ;
        endcase
        o.count = ilid_pkg::COUNT_W'(list_len);
        return o;
    endfunction

    function automatic list_req_t random_request(input int trend);
        list_req_t r;
        int        pick;
        int        c_app, c_ins, c_rd, c_wr, c_del;
        c_app = (trend == TREND_GROW) ? 40 : (trend == TREND_CHURN) ? 25 : 5;
        c_ins = (trend == TREND_GROW) ? 75 : (trend == TREND_CHURN) ? 45 : 10;
        c_rd  = (trend == TREND_GROW) ? 85 : (trend == TREND_CHURN) ? 60 : 20;
        c_wr  = (trend == TREND_GROW) ? 92 : (trend == TREND_CHURN) ? 70 : 28;
        c_del = (trend == TREND_GROW) ? 98 : (trend == TREND_CHURN) ? 96 : 97;
        pick = $urandom_range(99);
        if (pick < c_app) r.kind = ilid_pkg::REQ_APPEND;
        else if (pick < c_ins) r.kind = ilid_pkg::REQ_INSERT;
        else if (pick < c_rd) r.kind = ilid_pkg::REQ_READ;
        else if (pick < c_wr) r.kind = ilid_pkg::REQ_WRITE;
        else if (pick < c_del) r.kind = ilid_pkg::REQ_DELETE;
        else r.kind = ilid_pkg::TYPE_W'($urandom_range(REQ_RSVD7, REQ_RSVD5));
        r.word = $urandom();
        pick = $urandom_range(99);
        if (pick < 8) r.pos = ilid_pkg::POS_W'($urandom_range((1 << ilid_pkg::POS_W) - 1));
        else if (pick < 16) r.pos = ilid_pkg::POS_W'(list_len);
        else if (r.kind == ilid_pkg::REQ_INSERT) r.pos = ilid_pkg::POS_W'($urandom_range(list_len));
        else if (list_len == 0) r.pos = '0;
        else r.pos = ilid_pkg::POS_W'($urandom_range(list_len - 1));
        return r;
    endfunction

    task automatic add_row(input logic [ilid_pkg::TYPE_W-1:0] kind, input int pos,
                           input logic [ilid_pkg::WORD_W-1:0] word, input bit typed,
                           input logic [ilid_pkg::WORD_W-1:0] want_word,
                           input int want_count,
                           input logic [ilid_pkg::STATUS_W-1:0] want_status);
        table_row_t row;
        row.req.kind      = kind;
        row.req.pos       = ilid_pkg::POS_W'(pos);
        row.req.word      = word;
        row.typed         = typed;
        row.want.word_out = want_word;
        row.want.count    = ilid_pkg::COUNT_W'(want_count);
        row.want.status   = want_status;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input list_req_t r, input bit typed,
                                input ilid_pkg::res_t want);
        ilid_pkg::res_t predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= ilid_pkg::S_TDATA_W'({r.word, r.pos});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_side
        ilid_pkg::res_t got;
        ilid_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word_out = m_tdata[ilid_pkg::WORD_W-1:0];
            got.count    = m_tdata[ilid_pkg::WORD_W +: ilid_pkg::COUNT_W];
            got.status   = m_tuser;
            results_seen++;
            if (pending_results.size() == 0) begin
                log_error($sformatf("unexpected word: word_out %0d count %0d status %0d",
                                    got.word_out, got.count, got.status));
            end else begin
                want = pending_results.pop_front();
                if (got.word_out !== want.word_out)
                    log_error($sformatf("word_out got %0d want %0d",
                                        got.word_out, want.word_out));
                if (got.count !== want.count)
                    log_error($sformatf("count got %0d want %0d", got.count, want.count));
                if (got.status !== want.status)
                    log_error($sformatf("status got %0d want %0d", got.status, want.status));
            end
        end
    end

    always @(posedge aclk) begin : ready_side
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int             trend;
        int             churn_left;
        ilid_pkg::res_t no_want;
        trend      = TREND_GROW;
        churn_left = 0;
        no_want    = '0;

        add_row(ilid_pkg::REQ_READ,     0, 32'h0000_0000, 1, 32'h0000_0000, 0,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_WRITE,    0, 32'h0000_0005, 1, 32'h0000_0000, 0,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_DELETE,   0, 32'h0000_0000, 1, 32'h0000_0000, 0,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_INSERT,   1, 32'h0000_0007, 1, 32'h0000_0000, 0,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_INSERT, 511, 32'hFFFF_FFFF, 1, 32'h0000_0000, 0,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_APPEND,   0, 32'h8000_0000, 1, 32'h0000_0000, 1,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_INSERT,   0, 32'h7FFF_FFFF, 1, 32'h0000_0000, 2,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     0, 32'h0000_0000, 1, 32'h7FFF_FFFF, 2,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     1, 32'h0000_0000, 1, 32'h8000_0000, 2,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     2, 32'h0000_0000, 1, 32'h0000_0000, 2,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_INSERT,   2, 32'h0000_0000, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_INSERT,   4, 32'h0000_0001, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_WRITE,    1, 32'hFFFF_FFFF, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     1, 32'h0000_0000, 1, 32'hFFFF_FFFF, 3,
                ilid_pkg::ST_OK);
        add_row(REQ_RSVD5,              1, 32'h1234_5678, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_OK);
        add_row(REQ_RSVD6,              0, 32'hFFFF_FFFF, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_OK);
        add_row(REQ_RSVD7,            256, 32'h0000_0000, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_APPEND, 511, 32'h5555_5555, 1, 32'h0000_0000, 4,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_INSERT,   1, 32'h2AAA_AAAA, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     2, 32'h0000_0000, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_DELETE,   0, 32'h0000_0000, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,     0, 32'h0000_0000, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_DELETE,   3, 32'h0000_0000, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);
        add_row(ilid_pkg::REQ_READ,   256, 32'h0000_0000, 1, 32'h0000_0000, 3,
                ilid_pkg::ST_RANGE);
        add_row(ilid_pkg::REQ_DELETE,   2, 32'h0000_0000, 0, 32'h0000_0000, 0,
                ilid_pkg::ST_OK);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_all_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                wait_all_results();
                tx_idle_pct = 74;
                rx_idle_pct = 11;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                wait_all_results();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Fill the list, work it while full, then empty it again.
            if (trend == TREND_GROW && list_len == CAP) begin
                trend      = TREND_CHURN;
                churn_left = 80;
            end else if (trend == TREND_CHURN) begin
                churn_left--;
                if (churn_left == 0) trend = TREND_SHRINK;
            end else if (trend == TREND_SHRINK && list_len == 0) begin
                trend = TREND_GROW;
            end
            send_request(random_request(trend), 1'b0, no_want);
        end
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ilid_pkg.sv
rtl/ilid_ram.sv
rtl/ilid_seq.sv
rtl/indexed_list_insert_delete_unit.sv
rtl/ilid_chk.sv
test/tb_top.sv
